### rtl/core/fmn_pkg.sv
package fmn_pkg;

  // field widths fixed by the item format
  localparam int DATA_W    = 16;
  localparam int IDX_W     = 6;
  localparam int DIMS_W    = 7;
  localparam int SUM_W     = 40;
  // dividend of the rounded mean: 2*|sum| + count
  localparam int NUM_W     = SUM_W + 1;
  localparam int DIV_CNT_W = 6;
  localparam int RES_W     = NUM_W + 2;

  localparam logic [DIMS_W-1:0]    DIMS_RESET = 7'd13;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST   = DIV_CNT_W'(NUM_W - 1);

  // operation codes carried in the input tuser
  typedef enum logic [1:0] {
    OP_ACC   = 2'd0,
    OP_APPLY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LOAD,
    ST_DIV,
    ST_RESP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic rd_en;
    logic acc_wr;
    logic div_load;
    logic div_step;
    logic clear;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic in_range;
    logic count_zero;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

### rtl/core/fmn_ram.sv
module fmn_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/fmn_ctrl.sv
module fmn_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  fmn_pkg::sts_t sts,
  output fmn_pkg::cmd_t cmd
);

  fmn_pkg::state_t state_r;
  fmn_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fmn_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fmn_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = fmn_pkg::ST_DECODE;
        end
      end
      fmn_pkg::ST_DECODE: begin
        case (sts.op)
          fmn_pkg::OP_ACC: begin
            state_nxt = sts.in_range ? fmn_pkg::ST_LOAD : fmn_pkg::ST_RESP;
          end
          fmn_pkg::OP_APPLY: begin
            state_nxt = (sts.in_range && !sts.count_zero) ? fmn_pkg::ST_LOAD
                                                          : fmn_pkg::ST_RESP;
          end
          default: begin
            state_nxt = fmn_pkg::ST_RESP;
          end
        endcase
      end
      fmn_pkg::ST_LOAD: begin
        state_nxt = (sts.op == fmn_pkg::OP_APPLY) ? fmn_pkg::ST_DIV : fmn_pkg::ST_RESP;
      end
      fmn_pkg::ST_DIV: begin
        if (sts.div_last) begin
          state_nxt = fmn_pkg::ST_RESP;
        end
      end
      fmn_pkg::ST_RESP: begin
        if (sts.out_free) begin
          state_nxt = fmn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fmn_pkg::ST_IDLE;
      end
    endcase
  end

  // command outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      fmn_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      fmn_pkg::ST_DECODE: begin
        case (sts.op)
          fmn_pkg::OP_ACC: begin
            cmd.rd_en = sts.in_range;
          end
          fmn_pkg::OP_APPLY: begin
            cmd.rd_en = sts.in_range && !sts.count_zero;
          end
          fmn_pkg::OP_CLEAR: begin
            cmd.clear = 1'b1;
          end
          default: begin
            cmd.rd_en = 1'b0;
          end
        endcase
      end
      fmn_pkg::ST_LOAD: begin
        cmd.acc_wr   = (sts.op == fmn_pkg::OP_ACC);
        cmd.div_load = (sts.op == fmn_pkg::OP_APPLY);
      end
      fmn_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      fmn_pkg::ST_RESP: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### rtl/core/fmn_dp.sv
module fmn_dp #(
  parameter int MAX_DIMS   = 64,
  parameter int COUNT_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [fmn_pkg::DIMS_W-1:0]    cfg_data,
  input  logic [23:0]                   in_tdata,
  input  logic [1:0]                    in_tuser,
  input  fmn_pkg::cmd_t                 cmd,
  output fmn_pkg::sts_t                 sts,
  input  logic                          out_tready,
  output logic                          out_tvalid,
  output logic [15:0]                   out_tdata,
  output logic [0:0]                    out_tuser
);

  localparam int ADDR_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int DEN_W  = COUNT_BITS + 1;
  localparam int SUM_W  = fmn_pkg::SUM_W;
  localparam int NUM_W  = fmn_pkg::NUM_W;
  localparam int RES_W  = fmn_pkg::RES_W;
  localparam logic [8:0]            MAX_DIMS_V = 9'(MAX_DIMS);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};

  // input fields
  logic [fmn_pkg::IDX_W-1:0]         in_idx;
  logic signed [fmn_pkg::DATA_W-1:0] in_x;
  logic                              in_ok;

  // captured item
  fmn_pkg::op_t                      op_r;
  logic [ADDR_W-1:0]                 addr_r;
  logic                              idx_zero_r;
  logic signed [fmn_pkg::DATA_W-1:0] x_r;
  logic                              in_range_r;

  // statistics
  logic [fmn_pkg::DIMS_W-1:0] dims_r;
  logic [COUNT_BITS-1:0]      count_r;
  logic [MAX_DIMS-1:0]        vld_r;
  logic                       rd_vld_r;
  logic [SUM_W-1:0]           ram_rdata;
  logic signed [SUM_W-1:0]    sum_q;
  logic signed [SUM_W:0]      acc_sum;
  logic [SUM_W-1:0]           acc_sat;

  // divider
  logic [NUM_W-1:0]           div_num_r;
  logic [DEN_W-1:0]           div_rem_r;
  logic [DEN_W-1:0]           div_den_r;
  logic [fmn_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic                       sum_neg_r;
  logic [SUM_W:0]             sum_mag;
  logic [DEN_W:0]             div_trial;
  logic [DEN_W:0]             div_diff;
  logic                       div_ge;

  // result
  logic signed [RES_W-1:0]    res_diff;
  logic [fmn_pkg::DATA_W-1:0] res_sat;
  logic [fmn_pkg::DATA_W-1:0] res_val;
  logic                       res_err;
  logic                       out_vld_r;
  logic [fmn_pkg::DATA_W-1:0] out_val_r;
  logic                       out_err_r;

  assign in_idx = in_tdata[5:0];
  assign in_x   = in_tdata[21:6];
  assign in_ok  = ({1'b0, in_idx} < dims_r) && (9'(in_idx) < MAX_DIMS_V);

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= fmn_pkg::DIMS_RESET;
    end else if (cfg_valid) begin
      dims_r <= cfg_data;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= fmn_pkg::OP_NONE;
    end else if (cmd.capture) begin
      op_r <= fmn_pkg::op_t'(in_tuser);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_r     <= ADDR_W'(in_idx);
      idx_zero_r <= (in_idx == '0);
      x_r        <= in_x;
      in_range_r <= in_ok;
    end
  end

  // frame count, saturating on element zero
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      count_r <= '0;
    end else if (cmd.acc_wr && idx_zero_r && (count_r != COUNT_MAX)) begin
      count_r <= count_r + 1'b1;
    end
  end

  // per-entry valid bits, an invalid entry reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      vld_r <= '0;
    end else if (cmd.acc_wr) begin
      vld_r[addr_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_vld_r <= vld_r[addr_r];
    end
  end

  fmn_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_DIMS)
  ) u_sums (
    .clk   (clk),
    .we    (cmd.acc_wr),
    .waddr (addr_r),
    .wdata (acc_sat),
    .re    (cmd.rd_en),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  assign sum_q = rd_vld_r ? $signed(ram_rdata) : '0;

  // saturating accumulate
  assign acc_sum = {sum_q[SUM_W-1], sum_q} + (SUM_W+1)'(x_r);
  always_comb begin
    if (acc_sum[SUM_W] != acc_sum[SUM_W-1]) begin
      acc_sat = acc_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[SUM_W-1:0];
    end
  end

  // restoring divider, one quotient bit per cycle
  assign sum_mag   = sum_q[SUM_W-1] ? ((SUM_W+1)'(0) - {1'b1, sum_q})
                                    : {1'b0, sum_q};
  assign div_trial = {div_rem_r, div_num_r[NUM_W-1]};
  assign div_diff  = div_trial - {1'b0, div_den_r};
  assign div_ge    = (div_trial >= {1'b0, div_den_r});

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      div_num_r <= {sum_mag[SUM_W-1:0], 1'b0} + NUM_W'(count_r);
      div_rem_r <= '0;
      div_den_r <= {count_r, 1'b0};
      div_cnt_r <= '0;
      sum_neg_r <= sum_q[SUM_W-1];
    end else if (cmd.div_step) begin
      div_num_r <= {div_num_r[NUM_W-2:0], div_ge};
      div_rem_r <= div_ge ? div_diff[DEN_W-1:0] : div_trial[DEN_W-1:0];
      div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  // element minus rounded mean, saturated to 16 bits
  always_comb begin
    if (sum_neg_r) begin
      res_diff = RES_W'(x_r) + $signed({2'b00, div_num_r});
    end else begin
      res_diff = RES_W'(x_r) - $signed({2'b00, div_num_r});
    end
    if (res_diff > RES_W'(32767)) begin
      res_sat = 16'h7fff;
    end else if (res_diff < -RES_W'(32768)) begin
      res_sat = 16'h8000;
    end else begin
      res_sat = res_diff[fmn_pkg::DATA_W-1:0];
    end
  end

  // result select by operation
  always_comb begin
    res_val = '0;
    res_err = 1'b0;
    case (op_r)
      fmn_pkg::OP_APPLY: begin
        if (!in_range_r) begin
          res_val = x_r;
        end else if (count_r == '0) begin
          res_val = x_r;
          res_err = 1'b1;
        end else begin
          res_val = res_sat;
        end
      end
      default: begin
        res_val = '0;
        res_err = 1'b0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_val_r <= res_val;
      out_err_r <= res_err;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_val_r;
  assign out_tuser  = out_err_r;

  // status to the controller
  assign sts.op         = op_r;
  assign sts.in_range   = in_range_r;
  assign sts.count_zero = (count_r == '0);
  assign sts.div_last   = (div_cnt_r == fmn_pkg::DIV_LAST);
  assign sts.out_free   = !out_vld_r || out_tready;

endmodule

### rtl/core/feature_mean_normalizer.sv
// feature_mean_normalizer: per-dimension mean normalization of Q7.8 features
//
// input stream (in_*): in_tuser carries the operation (accumulate, apply,
// clear), in_tdata carries the dimension index and the feature element.
// result stream (out_*): one result transaction per input transaction, the
// normalized element in out_tdata and the no-statistics flag in out_tuser.
// config port (cfg_*): dims_in_use, always ready; write only while idle.
//
// one item is worked at a time. from input transaction to out_tvalid:
// clear, unused ops, out-of-range items and apply without stats pass the
// decode and response states; accumulate reads the sum memory in decode,
// then does the saturating add and write back in load; apply with stats
// reads in decode, loads, and runs the 41-step radix-2 divider for the rounded
// mean. in_tready returns together with out_tvalid, so a new item is taken only once the last result is loaded.
// reset clears all sums (per-entry valid bits), the frame count and sets
// dims_in_use to 13. a stalled receiver holds the result in the output
// register; the block can take the next item meanwhile and waits with its
// own result until that register frees.
module feature_mean_normalizer #(
  parameter int MAX_DIMS   = 64,
  parameter int COUNT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  // config write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,    // dims_in_use
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // elem_index[5:0], feature_value[21:6], zero
  input  logic [1:0]  in_tuser,    // op[1:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // normalized_value[15:0]
  output logic [0:0]  out_tuser    // no_stats_error[0]
);

  fmn_pkg::cmd_t cmd;
  fmn_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  fmn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fmn_dp #(
    .MAX_DIMS   (MAX_DIMS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

### rtl/core/fmn_chk.sv
module fmn_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a stalled result holds its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result payload changed while stalled");

  // one item at a time: no input right after an input transaction
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

  // a new result only comes out of a busy block
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result without work in flight");

endmodule

bind feature_mean_normalizer fmn_chk u_fmn_chk (.*);
